@@ rtl/core/bounded_vector_table_unit_assert.svh @@
// assertion macros shared by the list checker
// no dependencies; included by files that carry concurrent assertions
`ifndef BOUNDED_VECTOR_TABLE_UNIT_ASSERT_SVH
`define BOUNDED_VECTOR_TABLE_UNIT_ASSERT_SVH

// implication checked only outside reset
`define BVT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bvt assertion failed");

// next-cycle implication checked only outside reset
`define BVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bvt assertion failed");

// next-cycle implication that also holds through reset
`define BVT_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bvt assertion failed");

`endif

@@ rtl/core/bvt_pkg.sv @@
// types and constants of the bounded vector table
// no dependencies; used by every module of the block
`default_nettype none

package bvt_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int KIND_W       = 4;
  localparam int POS_W        = 16;
  localparam int VAL_W        = 32;
  localparam int RES_W        = 5;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 4'd0,
    KIND_DROP   = 4'd1,
    KIND_INSERT = 4'd2,
    KIND_ERASE  = 4'd3,
    KIND_READ   = 4'd4,
    KIND_FIRST  = 4'd5,
    KIND_LAST   = 4'd6,
    KIND_CLEAR  = 4'd7,
    KIND_WRITE  = 4'd8
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] read_value;
    logic [1:0]              status;
    logic [RES_W-1:0]        result_index;
    logic [RES_W-1:0]        entry_count;
    logic                    is_empty;
  } out_item_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic ers;
    logic wr;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/bvt_cell.sv @@
// one storage cell of the shift chain: holds one entry
// depends on bvt_pkg
`default_nettype none

module bvt_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4
) (
  input  wire logic                            clk,
  input  wire bvt_pkg::cell_ctl_t              ctl,
  input  wire logic [IDX_W-1:0]                tgt,
  input  wire logic signed [bvt_pkg::VAL_W-1:0] val,
  input  wire logic signed [bvt_pkg::VAL_W-1:0] left_d,
  input  wire logic signed [bvt_pkg::VAL_W-1:0] right_d,
  output logic signed [bvt_pkg::VAL_W-1:0]      data_q,
  output logic signed [bvt_pkg::VAL_W-1:0]      rd_d
);
  import bvt_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;

  // next entry: shift from a neighbor or load the new value
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (MY_IDX > tgt) data_nxt = left_d;
      else if (MY_IDX == tgt) data_nxt = val;
    end
    if (ctl.ers && (MY_IDX >= tgt)) data_nxt = right_d;
    if (ctl.wr && (MY_IDX == tgt)) data_nxt = val;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // entry gated onto the shared read bus when selected
  assign data_q = data_r;
  assign rd_d   = (MY_IDX == tgt) ? data_r : '0;

endmodule

`default_nettype wire

@@ rtl/core/bounded_vector_table_unit.sv @@
// top level of the bounded vector table: decode, count and cell chain
// depends on bvt_pkg and bvt_cell
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   bvt_pkg::in_item_t
//   out_     output     out_valid / out_ready bvt_pkg::out_item_t
//
// each request acts on the edge that accepts it; its result is registered and
// shown the next cycle. all cells shift in parallel, so insert and erase also
// act on that edge. in_ready is high out of reset while the output register
// is empty or being drained, so requests can follow back to back. rst_n is
// synchronous and clears the count and the output valid; stored entries are not
// cleared. a stalled output holds the result and blocks further requests.
`default_nettype none

module bounded_vector_table_unit #(
  parameter int CAPACITY = bvt_pkg::CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bvt_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bvt_pkg::out_item_t      out_data
);
  import bvt_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;

  logic             fire;
  cell_ctl_t        ctl;
  logic [IDX_W-1:0] tgt;
  logic             rd_en;
  logic             idx_set;
  logic [POS_W-1:0] n_ext;
  logic [POS_W-1:0] ins_pos;
  status_t          status;
  logic signed [VAL_W-1:0] rd_bus;

  logic signed [VAL_W-1:0] cell_q  [CAPACITY];
  logic signed [VAL_W-1:0] cell_rd [CAPACITY];

  assign fire     = in_valid && in_ready;
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign n_ext    = POS_W'(cnt_r);
  assign ins_pos  = (in_data.position > n_ext) ? n_ext : in_data.position;

  // request decode
  always_comb begin
    ctl     = '0;
    tgt     = IDX_W'(in_data.position);
    rd_en   = 1'b0;
    idx_set = 1'b0;
    status  = ST_OK;
    cnt_nxt = cnt_r;
    case (in_data.kind)
      KIND_APPEND: begin
        tgt = IDX_W'(cnt_r);
        if (cnt_r >= CAP_CNT) status = ST_FULL;
        else begin
          ctl.wr  = fire;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      KIND_DROP: begin
        if (cnt_r == '0) status = ST_EMPTY;
        else cnt_nxt = cnt_r - CNT_W'(1);
      end
      KIND_INSERT: begin
        tgt = IDX_W'(ins_pos);
        if (cnt_r >= CAP_CNT) status = ST_FULL;
        else begin
          ctl.ins = fire;
          idx_set = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      KIND_ERASE: begin
        if (in_data.position >= n_ext) status = ST_RANGE;
        else begin
          ctl.ers = fire;
          idx_set = 1'b1;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      KIND_READ: begin
        if (in_data.position >= n_ext) status = ST_RANGE;
        else rd_en = 1'b1;
      end
      KIND_FIRST: begin
        tgt = '0;
        if (cnt_r == '0) status = ST_EMPTY;
        else rd_en = 1'b1;
      end
      KIND_LAST: begin
        tgt = IDX_W'(cnt_r - CNT_W'(1));
        if (cnt_r == '0) status = ST_EMPTY;
        else rd_en = 1'b1;
      end
      KIND_CLEAR: begin
        cnt_nxt = '0;
      end
      KIND_WRITE: begin
        if (in_data.position >= n_ext) status = ST_RANGE;
        else ctl.wr = fire;
      end
      default: begin
      end
    endcase
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    if (i == 0) begin : g_head
      assign left_d = '0;
    end else begin : g_body
      assign left_d = cell_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_d = cell_q[i];
    end else begin : g_inner
      assign right_d = cell_q[i+1];
    end
    bvt_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .tgt     (tgt),
      .val     (in_data.item_value),
      .left_d  (left_d),
      .right_d (right_d),
      .data_q  (cell_q[i]),
      .rd_d    (cell_rd[i])
    );
  end

  // or of the gated cell outputs, at most one is nonzero
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // result assembly
  always_comb begin
    out_nxt.read_value   = rd_en ? rd_bus : '0;
    out_nxt.status       = status;
    out_nxt.result_index = idx_set ? RES_W'(tgt) : RES_W'(cnt_nxt);
    out_nxt.entry_count  = RES_W'(cnt_nxt);
    out_nxt.is_empty     = (cnt_nxt == '0);
  end

  // count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) cnt_r <= cnt_nxt;
      if (fire) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (fire) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ rtl/core/bvt_checker.sv @@
// port-level checks of the bounded vector table, bound to the top level
// depends on bvt_pkg and bounded_vector_table_unit_assert.svh
`default_nettype none

`include "bounded_vector_table_unit_assert.svh"

module bvt_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bvt_pkg::out_item_t out_data
);
  import bvt_pkg::*;

  // no result is pending right after reset
  `BVT_ASSERT_RST(a_rst_idle, clk, !rst_n, !out_valid)

  // a stalled result stays offered
  `BVT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // empty flag follows the count
  `BVT_ASSERT_IMPLY(a_empty, clk, rst_n, out_valid, out_data.is_empty == (out_data.entry_count == '0))

  // a rejected or failed request reads nothing
  `BVT_ASSERT_IMPLY(a_rd_zero, clk, rst_n, out_valid && (out_data.status != ST_OK), out_data.read_value == '0)

  // a full rejection reports the count as the index
  `BVT_ASSERT_IMPLY(a_full_idx, clk, rst_n, out_valid && (out_data.status == ST_FULL), out_data.result_index == out_data.entry_count)

endmodule

bind bounded_vector_table_unit bvt_checker u_bvt_checker (.*);

`default_nettype wire
